FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the date validator.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define DSV_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define DSV_ASSERT_RST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed during reset");

`endif

FILE: hw/rtl/dsv_pkg.sv
// Package for the ISO date string validator: item record, status codes,
// field classes and the month length function. No dependencies.
`timescale 1ns / 1ps

package dsv_pkg;

  localparam int unsigned DSV_FIFO_DEPTH = 2;   // queue entries, 2 or more
  localparam logic [3:0]  DSV_POS_SAT    = 4'd11;
  localparam logic [3:0]  DSV_DATE_LEN   = 4'd10;
  localparam logic [7:0]  DSV_DASH_CODE  = 8'h2D;
  localparam logic [7:0]  DSV_DIGIT_LO   = 8'h30;
  localparam logic [7:0]  DSV_DIGIT_HI   = 8'h39;
  localparam logic [13:0] DSV_MIN_YEAR_RST = 14'd1900;
  localparam logic [13:0] DSV_MAX_YEAR_RST = 14'd9999;

  // Configuration register indexes
  localparam logic DSV_REG_MIN_YEAR = 1'b0;
  localparam logic DSV_REG_MAX_YEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FORMAT      = 3'd1,
    ST_YEAR_DIGIT  = 3'd2,
    ST_YEAR_RANGE  = 3'd3,
    ST_MONTH_DIGIT = 3'd4,
    ST_MONTH_RANGE = 3'd5,
    ST_DAY_DIGIT   = 3'd6,
    ST_DAY_RANGE   = 3'd7
  } status_e;

  // Which part of the string a character belongs to
  typedef enum logic [2:0] {
    FLD_YEAR_HI,
    FLD_YEAR_LO,
    FLD_DASH,
    FLD_MONTH,
    FLD_DAY,
    FLD_NONE
  } field_e;

  // Classified character as passed from front to back
  typedef struct packed {
    field_e     field;
    logic       char_ok;   // digit in a digit field, dash in a dash field
    logic [3:0] digit;
    logic       last;
    logic       len_ok;    // string length is exactly ten, valid with last
  } dsv_item_t;

  // Days in a month; month is 1..12
  function automatic logic [4:0] dsv_month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    begin
      unique case (month)
        4'd2:                     len = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
        default:                  len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

FILE: hw/rtl/dsv_if.sv
// Channel interfaces of the date validator: character input and result output.
// Depends on nothing.
`timescale 1ns / 1ps

interface dsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dsv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [13:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;

  modport source (output valid, output status, output year_out, output month_out,
                  output day_out, input ready);
  modport sink   (input valid, input status, input year_out, input month_out,
                  input day_out, output ready);
endinterface

FILE: hw/rtl/dsv_front.sv
// Front end: takes characters, tracks the position and classifies each one.
// Depends on dsv_pkg.
`timescale 1ns / 1ps

module dsv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                char_valid_i,
  output logic                char_ready_o,
  input  logic [7:0]          char_code_i,
  input  logic                last_char_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output dsv_pkg::dsv_item_t  item_o
);
  import dsv_pkg::*;

  logic [3:0] pos_q, pos_d, pos_inc;
  logic       is_digit, is_dash, take;
  field_e     field;

  assign char_ready_o = item_ready_i;
  assign item_valid_o = char_valid_i;
  assign take         = char_valid_i && item_ready_i;

  assign is_digit = (char_code_i >= DSV_DIGIT_LO) && (char_code_i <= DSV_DIGIT_HI);
  assign is_dash  = (char_code_i == DSV_DASH_CODE);
  assign pos_inc  = (pos_q < DSV_POS_SAT) ? pos_q + 4'd1 : pos_q;

  // Map position to field
  always_comb begin
    unique case (pos_q)
      4'd0, 4'd1: field = FLD_YEAR_HI;
      4'd2, 4'd3: field = FLD_YEAR_LO;
      4'd4, 4'd7: field = FLD_DASH;
      4'd5, 4'd6: field = FLD_MONTH;
      4'd8, 4'd9: field = FLD_DAY;
      default:    field = FLD_NONE;
    endcase
  end

  // Build the record
  always_comb begin
    item_o.field   = field;
    item_o.char_ok = (field == FLD_DASH) ? is_dash : is_digit;
    item_o.digit   = is_digit ? char_code_i[3:0] : 4'd0;
    item_o.last    = last_char_i;
    item_o.len_ok  = (pos_inc == DSV_DATE_LEN);
  end

  // Advance the position, restart after the last character
  always_comb begin
    pos_d = pos_q;
    if (take) begin
      pos_d = last_char_i ? 4'd0 : pos_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

FILE: hw/rtl/dsv_fifo.sv
// Short queue of classified characters between front and back end.
// Depends on dsv_pkg.
`timescale 1ns / 1ps

module dsv_fifo #(
  parameter int unsigned Depth = dsv_pkg::DSV_FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  dsv_pkg::dsv_item_t  push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output dsv_pkg::dsv_item_t  pop_data_o
);
  import dsv_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  dsv_item_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    begin
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    end
  endfunction

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Move pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/dsv_back.sv
// Back end: accumulates fields, checks the date on the last character and
// holds the result register. Depends on dsv_pkg and dsv_if.
`timescale 1ns / 1ps

module dsv_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  dsv_pkg::dsv_item_t  item_i,
  input  logic [13:0]         min_year_i,
  input  logic [13:0]         max_year_i,
  dsv_out_if.source           out_o
);
  import dsv_pkg::*;

  logic        dash_err_q, dash_err_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d;
  logic [6:0]  day_q, day_d;
  logic [1:0]  hi4_q, hi4_d;     // first two year digits, mod 4
  logic [6:0]  lo_q, lo_d;       // last two year digits
  logic        ynd_q, ynd_d, mnd_q, mnd_d, dnd_q, dnd_d;

  logic        slot_free, pop, leap;
  logic [4:0]  mlen;
  status_e     status;

  logic        out_valid_q;
  status_e     status_q;
  logic [13:0] year_out_q;
  logic [3:0]  month_out_q;
  logic [4:0]  day_out_q;

  assign slot_free    = !out_valid_q || out_o.ready;
  assign item_ready_o = !item_i.last || slot_free;
  assign pop          = item_valid_i && item_ready_o;

  // Fold the character into the field accumulators
  always_comb begin
    dash_err_d = dash_err_q;
    year_d     = year_q;
    month_d    = month_q;
    day_d      = day_q;
    hi4_d      = hi4_q;
    lo_d       = lo_q;
    ynd_d      = ynd_q;
    mnd_d      = mnd_q;
    dnd_d      = dnd_q;
    unique case (item_i.field)
      FLD_DASH: begin
        if (!item_i.char_ok) dash_err_d = 1'b1;
      end
      FLD_YEAR_HI, FLD_YEAR_LO: begin
        if (!item_i.char_ok) begin
          ynd_d = 1'b1;
        end else begin
          year_d = {year_q[10:0], 3'b000} + {year_q[12:0], 1'b0} + {10'd0, item_i.digit};
          if (item_i.field == FLD_YEAR_HI) begin
            hi4_d = {hi4_q[0], 1'b0} + item_i.digit[1:0];
          end else begin
            lo_d = {lo_q[3:0], 3'b000} + {lo_q[5:0], 1'b0} + {3'd0, item_i.digit};
          end
        end
      end
      FLD_MONTH: begin
        if (!item_i.char_ok) begin
          mnd_d = 1'b1;
        end else begin
          month_d = {month_q[3:0], 3'b000} + {month_q[5:0], 1'b0} + {3'd0, item_i.digit};
        end
      end
      FLD_DAY: begin
        if (!item_i.char_ok) begin
          dnd_d = 1'b1;
        end else begin
          day_d = {day_q[3:0], 3'b000} + {day_q[5:0], 1'b0} + {3'd0, item_i.digit};
        end
      end
      default: begin
      end
    endcase
  end

  // Leap year from the two digit pairs; only used when all year digits are digits
  assign leap = (lo_d == 7'd0) ? (hi4_d == 2'd0) : (lo_d[1:0] == 2'd0);
  assign mlen = dsv_month_len(month_d[3:0], leap);

  // Check in priority order
  always_comb begin
    if (!item_i.len_ok || dash_err_d)                 status = ST_FORMAT;
    else if (ynd_d)                                   status = ST_YEAR_DIGIT;
    else if (year_d < min_year_i || year_d > max_year_i) status = ST_YEAR_RANGE;
    else if (mnd_d)                                   status = ST_MONTH_DIGIT;
    else if (month_d == 7'd0 || month_d > 7'd12)      status = ST_MONTH_RANGE;
    else if (dnd_d)                                   status = ST_DAY_DIGIT;
    else if (day_d == 7'd0 || day_d > {2'b00, mlen})  status = ST_DAY_RANGE;
    else                                              status = ST_OK;
  end

  // Hold the accumulators, clear after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dash_err_q <= 1'b0;
      year_q     <= '0;
      month_q    <= '0;
      day_q      <= '0;
      hi4_q      <= '0;
      lo_q       <= '0;
      ynd_q      <= 1'b0;
      mnd_q      <= 1'b0;
      dnd_q      <= 1'b0;
    end else if (pop) begin
      if (item_i.last) begin
        dash_err_q <= 1'b0;
        year_q     <= '0;
        month_q    <= '0;
        day_q      <= '0;
        hi4_q      <= '0;
        lo_q       <= '0;
        ynd_q      <= 1'b0;
        mnd_q      <= 1'b0;
        dnd_q      <= 1'b0;
      end else begin
        dash_err_q <= dash_err_d;
        year_q     <= year_d;
        month_q    <= month_d;
        day_q      <= day_d;
        hi4_q      <= hi4_d;
        lo_q       <= lo_d;
        ynd_q      <= ynd_d;
        mnd_q      <= mnd_d;
        dnd_q      <= dnd_d;
      end
    end
  end

  // Result register: load on the last character, drop once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && item_i.last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && item_i.last) begin
      status_q    <= status;
      year_out_q  <= (status == ST_OK) ? year_d : 14'd0;
      month_out_q <= (status == ST_OK) ? month_d[3:0] : 4'd0;
      day_out_q   <= (status == ST_OK) ? day_d[4:0] : 5'd0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = status_q;
  assign out_o.year_out  = year_out_q;
  assign out_o.month_out = month_out_q;
  assign out_o.day_out   = day_out_q;

endmodule

FILE: hw/rtl/iso_date_string_validator.sv
// Top level of the ISO date string validator: configuration registers and
// the front end, queue and back end. Depends on dsv_pkg, dsv_if and submodules.
//
//  channel | dir | transfer         | payload
//  --------+-----+------------------+-----------------------------------------
//  in_i    | in  | valid && ready   | char_code[7:0], last_char
//  out_o   | out | valid && ready   | status[2:0], year_out, month_out, day_out
//  APB     | in  | psel&penable&pwrite | paddr[2] selects min_year / max_year
//
// One character per cycle is taken while the queue has room; after the last
// character is transferred it passes through a queue entry, then the result
// register, from which the result transfers.
// The result register stalls only the last character of the next string;
// other characters go on into the two-entry queue until it fills.
// Reset clears the position, accumulators, queue and result valid; the
// year limits return to 1900 and 9999.
`timescale 1ns / 1ps

module iso_date_string_validator #(
  parameter int unsigned FifoDepth = dsv_pkg::DSV_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dsv_in_if.sink      in_i,
  dsv_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dsv_pkg::*;

  logic [13:0] min_year_q, max_year_q;
  logic        cfg_wr;

  logic        f_valid, f_ready, b_valid, b_ready;
  dsv_item_t   f_item, b_item;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == DSV_REG_MAX_YEAR) ? {18'd0, max_year_q} : {18'd0, min_year_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= DSV_MIN_YEAR_RST;
      max_year_q <= DSV_MAX_YEAR_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == DSV_REG_MIN_YEAR) begin
        min_year_q <= pwdata[13:0];
      end else begin
        max_year_q <= pwdata[13:0];
      end
    end
  end

  dsv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (in_i.valid),
    .char_ready_o (in_i.ready),
    .char_code_i  (in_i.char_code),
    .last_char_i  (in_i.last_char),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  dsv_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_item)
  );

  dsv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .item_i       (b_item),
    .min_year_i   (min_year_q),
    .max_year_i   (max_year_q),
    .out_o        (out_o)
  );

endmodule

FILE: hw/rtl/dsv_checker.sv
// Port-level checks on the result channel of the date validator, bound to
// the top level. Depends on dsv_pkg, dsv_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsv_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsv_out_if.source  out_o
);
  import dsv_pkg::*;

  logic fail;
  assign fail = (out_o.status != ST_OK);

  // No result while in reset
  `DSV_ASSERT_RST(a_no_result_in_reset, clk_i, !rst_ni |-> !out_o.valid)

  // Stalled result holds its valid, status, year and day
  `DSV_ASSERT(a_stall_hold, clk_i, rst_ni, out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.status) && $stable(out_o.year_out) && $stable(out_o.day_out))

  // A failed check carries zero fields
  `DSV_ASSERT(a_fail_zero, clk_i, rst_ni, out_o.valid && fail |-> out_o.year_out == 14'd0 && out_o.month_out == 4'd0 && out_o.day_out == 5'd0)

  // An accepted date has a month in range and a nonzero day
  `DSV_ASSERT(a_ok_range, clk_i, rst_ni, out_o.valid && !fail |-> out_o.month_out != 4'd0 && out_o.month_out <= 4'd12 && out_o.day_out != 5'd0)

endmodule

bind iso_date_string_validator dsv_checker u_dsv_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .out_o  (out_o)
);
